/* hw/rtl/pqks_pkg.sv */
// shared types and codes for the process queue with key search
`default_nettype none
package pqks_pkg;
  localparam int PID_W = 16;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int OUT_HANDLE_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ = 3'd0, FN_DEQ = 3'd1, FN_PEEK = 3'd2, FN_FIND = 3'd3,
    FN_REMOVE = 3'd4, FN_LIST_ALL = 3'd5, FN_LIST_CHILD = 3'd6, FN_CLEAR = 3'd7
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK = 2'd0, ST_NONE = 2'd1, ST_FULL = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load_op;    // capture the input word
    logic clr_idx;    // scan index to zero
    logic inc_idx;    // scan index plus one
    logic rd;         // read slot at scan index
    logic wr_tail;    // write new entry at the tail
    logic shift_wr;   // write the shifted entry at idx-1
    logic inc_cnt;
    logic dec_cnt;
    logic clr_cnt;
    logic load_out;   // capture a result word
    logic hold_pend;  // park matched listed pid as pending
    logic flush_pend; // emit pending as final or not
    logic pend_last;
    logic [STAT_W-1:0] st;
    logic use_slot;   // result data from slot read
  } pqks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic full;
    logic empty;
    logic idx_end;   // scan index reached entry count
    logic hit_pid;   // read slot pid equals key
    logic hit_par;   // read slot parent equals parent key
    logic pend_v;    // a listed pid waits to go out
    logic shift_end; // scan index passed entry count
  } pqks_stat_t;
endpackage
`default_nettype wire

/* hw/rtl/pqks_if.sv */
// valid/ready channel interface
`default_nettype none
interface pqks_if #(parameter int W = 1) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/process_queue_with_key_search_unit.sv */
// top level: process queue with associative search and removal
// enqueue, clear and empty-queue cases answer from dispatch once the output is free
// find/remove/list read and evaluate one slot at a time; remove shifts tail entries down
// throughput: one operation at a time, the scan and shift over the slot memories set the rate
// a result waits in an output register; the next item is taken once the controller is idle
// reset (synchronous, rst_n low) empties the queue; slot contents stay undefined until written
`default_nettype none
module process_queue_with_key_search_unit #(
  parameter int DEPTH = 64,
  parameter int HANDLE_BITS = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  pqks_if.sink in_ch,
  pqks_if.source out_ch
);
  import pqks_pkg::*;

  pqks_cmd_t cmd;
  pqks_stat_t stat;
  logic in_rdy, out_vld;
  logic [1:0] o_status;
  logic [7:0] o_handle;
  logic [15:0] o_pid;
  logic o_now_empty, o_last;

  // input word layout: func, handle, key_pid, parent_pid (msb first)
  pqks_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && in_rdy), .in_rdy(in_rdy),
    .out_vld(out_vld), .out_rdy(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  pqks_dp #(.DEPTH(DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_func(in_ch.data[42:40]), .in_handle(in_ch.data[39:32]),
    .in_key_pid(in_ch.data[31:16]), .in_parent_pid(in_ch.data[15:0]),
    .o_status(o_status), .o_handle(o_handle), .o_pid(o_pid),
    .o_now_empty(o_now_empty), .o_last(o_last)
  );

  assign in_ch.ready = in_rdy;
  assign out_ch.valid = out_vld;
  // result word layout: status, out_handle, out_pid, now_empty, last
  assign out_ch.data = {o_status, o_handle, o_pid, o_now_empty, o_last};
endmodule
`default_nettype wire

/* hw/rtl/pqks_dp.sv */
// datapath: slot memories, count, scan index and result register
`default_nettype none
module pqks_dp #(
  parameter int DEPTH = 64,
  parameter int HANDLE_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pqks_pkg::pqks_cmd_t cmd,
  output pqks_pkg::pqks_stat_t stat,
  input  wire logic [2:0] in_func,
  input  wire logic [7:0] in_handle,
  input  wire logic [15:0] in_key_pid,
  input  wire logic [15:0] in_parent_pid,
  output logic [1:0] o_status,
  output logic [7:0] o_handle,
  output logic [15:0] o_pid,
  output logic o_now_empty,
  output logic o_last
);
  import pqks_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [HANDLE_BITS-1:0] mem_h [DEPTH];
  logic [PID_W-1:0] mem_p [DEPTH];
  logic [PID_W-1:0] mem_q [DEPTH];

  logic [FUNC_W-1:0] func_r;
  logic [HANDLE_BITS-1:0] hin_r;
  logic [PID_W-1:0] key_r, par_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic [HANDLE_BITS-1:0] rd_h_r;
  logic [PID_W-1:0] rd_p_r, rd_q_r;
  logic pend_v_r;
  logic [PID_W-1:0] pend_r;
  logic [CW-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr_cnt) cnt_nxt = '0;
    else if (cmd.inc_cnt) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.dec_cnt) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      func_r <= in_func;
      hin_r <= in_handle[HANDLE_BITS-1:0];
      key_r <= in_key_pid;
      par_r <= in_parent_pid;
    end
    if (cmd.rd) begin
      rd_h_r <= mem_h[idx_r[AW-1:0]];
      rd_p_r <= mem_p[idx_r[AW-1:0]];
      rd_q_r <= mem_q[idx_r[AW-1:0]];
    end
    if (cmd.wr_tail) begin
      mem_h[cnt_r[AW-1:0]] <= hin_r;
      mem_p[cnt_r[AW-1:0]] <= key_r;
      mem_q[cnt_r[AW-1:0]] <= par_r;
    end else if (cmd.shift_wr) begin
      mem_h[AW'(idx_r - CW'(1))] <= rd_h_r;
      mem_p[AW'(idx_r - CW'(1))] <= rd_p_r;
      mem_q[AW'(idx_r - CW'(1))] <= rd_q_r;
    end
    if (cmd.hold_pend) pend_r <= rd_p_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      pend_v_r <= 1'b0;
      o_last <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.clr_idx) idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + CW'(1);
      if (cmd.hold_pend) pend_v_r <= 1'b1;
      else if (cmd.flush_pend) pend_v_r <= 1'b0;
      if (cmd.load_out) o_last <= cmd.pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status <= cmd.st;
      o_now_empty <= (cnt_nxt == '0);
      if (cmd.flush_pend) begin
        o_handle <= '0;
        o_pid <= pend_r;
      end else if (cmd.use_slot) begin
        o_handle <= OUT_HANDLE_W'(rd_h_r);
        o_pid <= rd_p_r;
      end else begin
        o_handle <= '0;
        o_pid <= '0;
      end
    end
  end

  always_comb begin
    stat.func = func_r;
    stat.full = (cnt_r == CW'(DEPTH));
    stat.empty = (cnt_r == '0);
    stat.idx_end = (idx_r >= cnt_r);
    stat.hit_pid = (rd_p_r == key_r);
    stat.hit_par = (rd_q_r == par_r);
    stat.pend_v = pend_v_r;
    // count already dropped for the removed entry
    stat.shift_end = (idx_r > cnt_r);
  end
endmodule
`default_nettype wire

/* hw/rtl/pqks_ctrl.sv */
// controller: sequences queue operations and result words
`default_nettype none
module pqks_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  output logic in_rdy,
  output logic out_vld,
  input  wire logic out_rdy,
  input  wire pqks_pkg::pqks_stat_t stat,
  output pqks_pkg::pqks_cmd_t cmd
);
  import pqks_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_EVAL, S_SHIFT_RD, S_SHIFT_WR, S_DONE, S_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic out_vld_r, out_vld_nxt;
  logic found_r, found_nxt;     // dequeue or remove match seen, shifting out of it
  logic any_r, any_nxt;         // list emitted something

  // a new word may load only when the result register is free
  logic oreg_free;
  assign oreg_free = !out_vld_r || out_rdy;

  always_comb begin
    state_nxt = state_r;
    out_vld_nxt = out_vld_r && !out_rdy;
    found_nxt = found_r;
    any_nxt = any_r;
    cmd = '0;
    cmd.st = ST_OK;
    cmd.pend_last = 1'b1;
    in_rdy = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.load_op = 1'b1;
          cmd.clr_idx = 1'b1;
          found_nxt = 1'b0;
          any_nxt = 1'b0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (oreg_free) begin
          case (stat.func)
            FN_ENQ: begin
              cmd.load_out = 1'b1;
              out_vld_nxt = 1'b1;
              if (stat.full) begin
                cmd.st = ST_FULL;
              end else begin
                cmd.wr_tail = 1'b1;
                cmd.inc_cnt = 1'b1;
              end
              state_nxt = S_IDLE;
            end
            FN_CLEAR: begin
              cmd.load_out = 1'b1;
              out_vld_nxt = 1'b1;
              cmd.clr_cnt = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              if (stat.empty) begin
                cmd.load_out = 1'b1;
                out_vld_nxt = 1'b1;
                cmd.st = ST_NONE;
                state_nxt = S_IDLE;
              end else begin
                cmd.rd = 1'b1;
                cmd.inc_idx = 1'b1;
                state_nxt = S_EVAL;
              end
            end
          endcase
        end
      end
      S_RD: begin
        if (stat.idx_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd = 1'b1;
          cmd.inc_idx = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // rd data holds slot idx-1
        case (stat.func)
          FN_DEQ, FN_PEEK: begin
            if (oreg_free) begin
              cmd.load_out = 1'b1;
              cmd.use_slot = 1'b1;
              out_vld_nxt = 1'b1;
              if (stat.func == FN_DEQ) begin
                // count drops with the result so now_empty reflects the removal
                cmd.dec_cnt = 1'b1;
                found_nxt = 1'b1;
                state_nxt = S_SHIFT_RD;
              end else begin
                state_nxt = S_IDLE;
              end
            end
          end
          FN_FIND, FN_REMOVE: begin
            if (stat.hit_pid) begin
              if (oreg_free) begin
                cmd.load_out = 1'b1;
                cmd.use_slot = 1'b1;
                out_vld_nxt = 1'b1;
                if (stat.func == FN_REMOVE) begin
                  cmd.dec_cnt = 1'b1;
                  found_nxt = 1'b1;
                  state_nxt = S_SHIFT_RD;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
            end else begin
              state_nxt = S_RD;
            end
          end
          default: begin
            // list: previous pending goes out (not last), new match parks
            if (stat.func == FN_LIST_ALL || stat.hit_par) begin
              if (!stat.pend_v) begin
                cmd.hold_pend = 1'b1;
                any_nxt = 1'b1;
                state_nxt = S_RD;
              end else if (oreg_free) begin
                cmd.load_out = 1'b1;
                cmd.flush_pend = 1'b1;
                cmd.pend_last = 1'b0;
                out_vld_nxt = 1'b1;
                cmd.hold_pend = 1'b1;
                state_nxt = S_RD;
              end
            end else begin
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        // idx points one past the removed slot; move entries down
        if (stat.shift_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.inc_idx = 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_DONE: begin
        // end of scan
        if (oreg_free) begin
          cmd.load_out = 1'b1;
          out_vld_nxt = 1'b1;
          if (stat.func == FN_LIST_ALL || stat.func == FN_LIST_CHILD) begin
            if (any_r) begin
              cmd.flush_pend = 1'b1;
            end else begin
              cmd.st = ST_NONE;
            end
          end else begin
            cmd.st = ST_NONE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_vld_r <= 1'b0;
      found_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_vld_r <= out_vld_nxt;
      found_r <= found_nxt;
      any_r <= any_nxt;
    end
  end

  assign out_vld = out_vld_r;

  a_shift_only_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> found_r) else $error("shift without removal");
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_rdy |-> state_r == S_IDLE) else $error("ready outside idle");
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> oreg_free) else $error("result overwritten");
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// testbench for the process queue with key search: directed table, then random traffic
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import pqks_pkg::*;

  localparam int DEPTH        = 64;
  localparam int GAP_MAX      = 12;
  localparam int STALL_LIMIT  = 3000;  // cycles with no word moving on either side
  localparam int RAND_OPS     = 70;

  // word layouts on the two channels, first field in the top bits
  typedef struct packed {
    func_t       fn;
    logic [7:0]  handle;
    logic [15:0] key_pid;
    logic [15:0] parent_pid;
  } op_word_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  handle;
    logic [15:0] pid;
    logic        now_empty;
    logic        last;
  } res_word_t;

  // one row of the directed table; typed result only where chk is set
  typedef struct packed {
    func_t       fn;
    logic [7:0]  h;
    logic [15:0] k;
    logic [15:0] p;
    logic        chk;
    status_t     st;
    logic [7:0]  eh;
    logic [15:0] ep;
    logic        ee;
  } dir_row_t;

  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    // every read or search on an empty queue reports nothing there; clear reports ok
    '{FN_DEQ,        8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_PEEK,       8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_FIND,       8'h00, 16'hffff, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_REMOVE,     8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_LIST_ALL,   8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_LIST_CHILD, 8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_CLEAR,      8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b1},
    // extremes of the fields, plus a duplicate pid
    '{FN_ENQ,        8'hff, 16'hffff, 16'hffff, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_ENQ,        8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_ENQ,        8'ha5, 16'h1234, 16'hffff, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_ENQ,        8'h5a, 16'h0000, 16'h0008, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_PEEK,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_FIND,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_LIST_ALL,   8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_LIST_CHILD, 8'h00, 16'h0000, 16'hffff, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_LIST_CHILD, 8'h00, 16'h0000, 16'h0007, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b0},
    // remove from the middle, then look for it again
    '{FN_REMOVE,     8'h00, 16'h1234, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_FIND,       8'h00, 16'h1234, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b0},
    '{FN_DEQ,        8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_REMOVE,     8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_FIND,       8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_DEQ,        8'h00, 16'h0000, 16'h0000, 1'b0, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_DEQ,        8'h00, 16'h0000, 16'h0000, 1'b1, ST_NONE, 8'h00, 16'h0000, 1'b1},
    '{FN_ENQ,        8'h3c, 16'h0001, 16'h0002, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b0},
    '{FN_CLEAR,      8'h00, 16'h0000, 16'h0000, 1'b1, ST_OK,   8'h00, 16'h0000, 1'b1}
  };

  logic clk;
  logic rst_n;

  pqks_if #(.W($bits(op_word_t)))  in_ch  (clk);
  pqks_if #(.W($bits(res_word_t))) out_ch (clk);

  process_queue_with_key_search_unit #(
    .DEPTH(DEPTH),
    .HANDLE_BITS(8)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow copy of the queue contents
  logic [7:0]  q_handle [DEPTH];
  logic [15:0] q_pid    [DEPTH];
  logic [15:0] q_parent [DEPTH];
  int          q_count;

  res_word_t result_q [$];   // results still owed by the block
  int        err_cnt;
  int        ops_sent;
  int        words_seen;
  int        full_hits;
  int        longest_list;

  function automatic void owe(status_t st, logic [7:0] h, logic [15:0] pid, logic last);
    res_word_t r;
    r.status    = st;
    r.handle    = h;
    r.pid       = pid;
    r.now_empty = (q_count == 0);
    r.last      = last;
    result_q.push_back(r);
  endfunction

  // close the gap left by slot idx, keeping arrival order
  function automatic void drop_entry(int idx);
    for (int j = idx; j + 1 < q_count; j++) begin
      q_handle[j] = q_handle[j+1];
      q_pid[j]    = q_pid[j+1];
      q_parent[j] = q_parent[j+1];
    end
    q_count--;
  endfunction

  // apply one operation to the shadow queue and queue up what it must return
  function automatic void queue_apply(op_word_t w);
    int          idx;
    int          n;
    logic [7:0]  h;
    logic [15:0] pid;
    idx = -1;
    n   = 0;
    case (w.fn)
      FN_ENQ: begin
        if (q_count >= DEPTH) begin
          full_hits++;
          owe(ST_FULL, 8'h00, 16'h0000, 1'b1);
        end else begin
          q_handle[q_count] = w.handle;
          q_pid[q_count]    = w.key_pid;
          q_parent[q_count] = w.parent_pid;
          q_count++;
          owe(ST_OK, 8'h00, 16'h0000, 1'b1);
        end
      end
      FN_DEQ, FN_PEEK: begin
        if (q_count == 0) begin
          owe(ST_NONE, 8'h00, 16'h0000, 1'b1);
        end else begin
          h   = q_handle[0];
          pid = q_pid[0];
          if (w.fn == FN_DEQ) drop_entry(0);
          owe(ST_OK, h, pid, 1'b1);
        end
      end
      FN_FIND, FN_REMOVE: begin
        for (int i = 0; i < q_count; i++)
          if (idx < 0 && q_pid[i] == w.key_pid) idx = i;
        if (idx < 0) begin
          owe(ST_NONE, 8'h00, 16'h0000, 1'b1);
        end else begin
          h   = q_handle[idx];
          pid = q_pid[idx];
          if (w.fn == FN_REMOVE) drop_entry(idx);
          owe(ST_OK, h, pid, 1'b1);
        end
      end
      FN_LIST_ALL, FN_LIST_CHILD: begin
        for (int i = 0; i < q_count; i++)
          if (w.fn == FN_LIST_ALL || q_parent[i] == w.parent_pid) begin
            owe(ST_OK, 8'h00, q_pid[i], 1'b0);
            n++;
          end
        if (n == 0) owe(ST_NONE, 8'h00, 16'h0000, 1'b1);
        else result_q[$].last = 1'b1;
        if (n > longest_list) longest_list = n;
      end
      default: begin
        q_count = 0;
        owe(ST_OK, 8'h00, 16'h0000, 1'b1);
      end
    endcase
  endfunction

  // draw an idle count; some words go back to back
  function automatic int draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // drive one word, wait for the handshake, then book its results
  task automatic send_op(op_word_t w, logic chk, res_word_t typed);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    queue_apply(w);
    // typed rows are single-result; they replace the predicted one
    if (chk) begin
      void'(result_q.pop_back());
      result_q.push_back(typed);
    end
    ops_sent++;
  endtask

  // mostly small pid and parent pools so searches hit, with the full range now and then
  function automatic op_word_t rand_op();
    op_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 35)      w.fn = FN_ENQ;
    else if (r < 45) w.fn = FN_DEQ;
    else if (r < 52) w.fn = FN_PEEK;
    else if (r < 64) w.fn = FN_FIND;
    else if (r < 78) w.fn = FN_REMOVE;
    else if (r < 85) w.fn = FN_LIST_ALL;
    else if (r < 96) w.fn = FN_LIST_CHILD;
    else             w.fn = FN_CLEAR;
    w.handle     = $urandom_range(0, 255);
    w.key_pid    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 15);
    w.parent_pid = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 3);
    return w;
  endfunction

  // result side: random hold-offs on ready, one word at a time
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // result check and stall watchdog
  int idle_cycles;
  always @(posedge clk) begin
    res_word_t got;
    res_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      words_seen++;
      if (result_q.size() == 0) begin
        $error("unexpected result word: %h", got);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_cnt++;
        end
        if (got.handle !== want.handle) begin
          $error("out_handle: expected %h, got %h", want.handle, got.handle);
          err_cnt++;
        end
        if (got.pid !== want.pid) begin
          $error("out_pid: expected %h, got %h", want.pid, got.pid);
          err_cnt++;
        end
        if (got.now_empty !== want.now_empty) begin
          $error("now_empty: expected %0b, got %0b", want.now_empty, got.now_empty);
          err_cnt++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          err_cnt++;
        end
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    op_word_t w;
    res_word_t typed;
    err_cnt      = 0;
    ops_sent     = 0;
    words_seen   = 0;
    full_hits    = 0;
    longest_list = 0;
    q_count      = 0;
    idle_cycles  = 0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed table
    foreach (DIR_TAB[i]) begin
      w.fn         = DIR_TAB[i].fn;
      w.handle     = DIR_TAB[i].h;
      w.key_pid    = DIR_TAB[i].k;
      w.parent_pid = DIR_TAB[i].p;
      typed.status    = DIR_TAB[i].st;
      typed.handle    = DIR_TAB[i].eh;
      typed.pid       = DIR_TAB[i].ep;
      typed.now_empty = DIR_TAB[i].ee;
      typed.last      = 1'b1;
      send_op(w, DIR_TAB[i].chk, typed);
    end

    // random traffic, with a drain pause and a fill to full partway through
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n == RAND_OPS / 3) begin
        @(negedge clk) in_ch.valid <= 1'b0;
        wait (result_q.size() == 0);
      end
      if (n == RAND_OPS / 2) begin
        // fill past capacity, list the lot and one parent's children, then remove by the last pid
        while (q_count < DEPTH + 2) begin
          w = rand_op();
          w.fn = FN_ENQ;
          send_op(w, 1'b0, typed);
          if (full_hits >= 2) break;
        end
        w.fn = FN_LIST_ALL;
        send_op(w, 1'b0, typed);
        w.fn = FN_LIST_CHILD;
        send_op(w, 1'b0, typed);
        w.fn      = FN_REMOVE;
        w.key_pid = q_pid[DEPTH-1];
        send_op(w, 1'b0, typed);
      end
      send_op(rand_op(), 1'b0, typed);
    end

    @(negedge clk) in_ch.valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("ran %0d operations, checked %0d result words", ops_sent, words_seen);
    $display("queue overflowed %0d times, longest list run %0d words", full_hits, longest_list);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/pqks_pkg.sv
hw/rtl/pqks_if.sv
hw/rtl/pqks_dp.sv
hw/rtl/pqks_ctrl.sv
hw/rtl/process_queue_with_key_search_unit.sv
sim/tb_top.sv
